>>> rtl/core/oal_pkg.sv
// ----------------------------------------------------------------------------
// oal_pkg: shared types and codes of the ordered array list
// Request and result item layouts, request kinds, status codes and the
// control bundle that the top level broadcasts to every list cell.
// ----------------------------------------------------------------------------
package oal_pkg;

	// request kinds
	localparam logic [2:0] KIND_INSERT = 3'd0;
	localparam logic [2:0] KIND_REMOVE = 3'd1;
	localparam logic [2:0] KIND_EXISTS = 3'd2;
	localparam logic [2:0] KIND_READ   = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic [2:0]  kind;
		logic [6:0]  position;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        found;
		logic [6:0]  entry_count;
		logic [1:0]  status;
	} res_t;

	// broadcast to all cells
	typedef struct packed {
		logic compare;   // register match and read select
		logic insert;    // commit an insert at the request position
		logic remove;    // close the gap at the first match
	} cell_ctrl_t;

endpackage

>>> rtl/core/oal_prefix.sv
// ----------------------------------------------------------------------------
// oal_prefix: inclusive prefix OR
// Marks every cell at or above the lowest set bit, in log2(N) levels.
// ----------------------------------------------------------------------------
module oal_prefix #(
	parameter int N = 64
) (
	input  logic [N-1:0] bits,
	output logic [N-1:0] at_or_above
);

	localparam int LEVELS = $clog2(N);

	logic [N-1:0] lvl [LEVELS+1];

	always_comb begin
		lvl[0] = bits;
		for (int k = 0; k < LEVELS; k++) begin
			lvl[k+1] = lvl[k] | (lvl[k] << (1 << k));
		end
	end

	assign at_or_above = lvl[LEVELS];

endmodule

>>> rtl/core/oal_cell.sv
// ----------------------------------------------------------------------------
// oal_cell: one list cell
// Holds one word, compares it with the request, and loads the request value
// or its lower neighbor on insert, or its upper neighbor on remove.
// ----------------------------------------------------------------------------
module oal_cell #(
	parameter int WORD_BITS = 32,
	parameter int CMP_W     = 7,
	parameter int IDX       = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  oal_pkg::cell_ctrl_t   ctrl,
	input  logic [CMP_W-1:0]      pos,
	input  logic [CMP_W-1:0]      count,
	input  logic [WORD_BITS-1:0]  value,
	input  logic [WORD_BITS-1:0]  lower_word,
	input  logic [WORD_BITS-1:0]  upper_word,
	input  logic                  take_upper,
	output logic [WORD_BITS-1:0]  word,
	output logic                  hit,
	output logic [WORD_BITS-1:0]  sel
);

	localparam logic [CMP_W-1:0] IDX_C = CMP_W'(IDX);

	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] sel_q;
	logic                 hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.compare) begin
			hit_q <= (IDX_C < count) && (word_q == value);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.compare) begin
			sel_q <= (IDX_C == pos) ? word_q : '0;
		end
		if (ctrl.insert) begin
			if (IDX_C == pos) begin
				word_q <= value;
			end else if (IDX_C > pos) begin
				word_q <= lower_word;
			end
		end else if (ctrl.remove && take_upper) begin
			word_q <= upper_word;
		end
	end

	assign word = word_q;
	assign hit  = hit_q;
	assign sel  = sel_q;

endmodule

>>> rtl/core/ordered_array_list_top.sv
// ----------------------------------------------------------------------------
// ordered_array_list_top: bounded ordered list of words
// Shift-register list of CAPACITY cells with insert, remove, membership,
// read and clear requests and one result per request.
// ----------------------------------------------------------------------------
// For each item the accept edge registers the request, the compare state
// lets every cell register its compare and read select, and the apply
// state resolves the first match through the prefix-OR tree and shifts the
// whole cell row at once. The result shows on "result" for one cycle with
// "done" high; busy is already low in that cycle, so a new item can be
// started alongside it, but no new item is taken while busy. The receiver
// cannot stall: take each result in its done cycle.
// Rejected requests (full list, bad position, value missing) leave the list
// unchanged. Entries at or above the count are never read.
module ordered_array_list_top #(
	parameter int CAPACITY  = 64,
	parameter int WORD_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  oal_pkg::req_t  request,
	output logic           done,
	output oal_pkg::res_t  result
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;   // holds count and position
	localparam int VB    = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CMP   = 3'b010,
		S_APPLY = 3'b100
	} state_t;

	state_t              state_q;
	oal_pkg::req_t       req_q;
	logic [CNT_W-1:0]    count_q;
	oal_pkg::res_t       res_q;
	logic                done_q;

	// cell row
	oal_pkg::cell_ctrl_t  ctrl;
	logic [WORD_BITS-1:0] words [CAPACITY];
	logic [WORD_BITS-1:0] sels  [CAPACITY];
	logic [CAPACITY-1:0]  hits;
	logic [CAPACITY-1:0]  take_upper;

	logic [WORD_BITS-1:0] value_w;
	logic [CMP_W-1:0]     pos_ext;
	logic [CMP_W-1:0]     cnt_ext;

	// apply-cycle decisions
	logic                 any_hit;
	logic [WORD_BITS-1:0] rd_or;
	logic                 do_insert;
	logic                 do_remove;
	logic [CNT_W-1:0]     count_d;
	oal_pkg::res_t        res_d;
	logic [CMP_W-1:0]     count_d_ext;

	// only the low WORD_BITS of the value are stored and compared
	always_comb begin
		value_w = '0;
		value_w[VB-1:0] = req_q.value[VB-1:0];
	end

	assign pos_ext = CMP_W'(req_q.position);
	assign cnt_ext = CMP_W'(count_q);

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					state_q <= S_IDLE;
					count_q <= count_d;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= request;
		end
		if (state_q == S_APPLY) begin
			res_q <= res_d;
		end
	end

	// first match: every cell at or above it pulls from its upper neighbor
	oal_prefix #(
		.N(CAPACITY)
	) u_prefix (
		.bits        (hits),
		.at_or_above (take_upper)
	);

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | sels[i];
		end
	end

	assign any_hit = |hits;

	// request resolution, evaluated in the apply cycle
	always_comb begin
		do_insert = 1'b0;
		do_remove = 1'b0;
		count_d   = count_q;
		res_d     = '0;
		res_d.status = oal_pkg::ST_OK;
		unique case (req_q.kind)
			oal_pkg::KIND_INSERT: begin
				if (pos_ext > cnt_ext) begin
					res_d.status = oal_pkg::ST_RANGE;
				end else if (count_q == CAP_C) begin
					res_d.status = oal_pkg::ST_FULL;
				end else begin
					do_insert = 1'b1;
					count_d   = count_q + 1'b1;
				end
			end
			oal_pkg::KIND_REMOVE: begin
				if (any_hit) begin
					do_remove   = 1'b1;
					res_d.found = 1'b1;
					count_d     = count_q - 1'b1;
				end else begin
					res_d.status = oal_pkg::ST_MISSING;
				end
			end
			oal_pkg::KIND_EXISTS: begin
				res_d.found = any_hit;
			end
			oal_pkg::KIND_READ: begin
				if (pos_ext >= cnt_ext) begin
					res_d.status = oal_pkg::ST_RANGE;
				end else begin
					res_d.read_value[VB-1:0] = rd_or[VB-1:0];
				end
			end
			oal_pkg::KIND_CLEAR: begin
				count_d = '0;
			end
			default: begin
				// unused kinds do nothing
			end
		endcase
		count_d_ext       = CMP_W'(count_d);
		res_d.entry_count = count_d_ext[6:0];
	end

	always_comb begin
		ctrl         = '0;
		ctrl.compare = (state_q == S_CMP);
		ctrl.insert  = (state_q == S_APPLY) && do_insert;
		ctrl.remove  = (state_q == S_APPLY) && do_remove;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] lower_w;
		logic [WORD_BITS-1:0] upper_w;

		// end cells feed back their own word
		if (i == 0) begin : g_lo_end
			assign lower_w = words[i];
		end else begin : g_lo
			assign lower_w = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi_end
			assign upper_w = words[i];
		end else begin : g_hi
			assign upper_w = words[i+1];
		end

		oal_cell #(
			.WORD_BITS (WORD_BITS),
			.CMP_W     (CMP_W),
			.IDX       (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.pos        (pos_ext),
			.count      (cnt_ext),
			.value      (value_w),
			.lower_word (lower_w),
			.upper_word (upper_w),
			.take_upper (take_upper[i]),
			.word       (words[i]),
			.hit        (hits[i]),
			.sel        (sels[i])
		);
	end

	assign done   = done_q;
	assign result = res_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------

	// a result only appears once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted item always produces a result strobe
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted item without result");

	// the entry count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	// a nonzero read value only comes from a successful read
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.read_value != '0)) |->
			(result.status == oal_pkg::ST_OK && !result.found))
		else $error("read value on a failed or non-read request");

endmodule
